>>> hdl/fair_credit_pool_allocator_unit_assert.svh
// Assertion macros shared by the credit pool allocator modules.
`ifndef FAIR_CREDIT_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FAIR_CREDIT_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCPA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("credit pool assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("credit pool assertion failed");

`endif

>>> hdl/fcpa_pkg.sv
// Shared types and codes for the credit pool allocator.
`default_nettype none

package fcpa_pkg;

    localparam logic ACT_RESERVE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_REFUSED   = 3'd1;
    localparam logic [2:0] ST_QUEUED    = 3'd2;
    localparam logic [2:0] ST_QFULL     = 3'd3;
    localparam logic [2:0] ST_RELEASED  = 3'd4;
    localparam logic [2:0] ST_UNDERFLOW = 3'd5;

    typedef struct packed {
        logic        action;
        logic [15:0] request_count;
        logic        no_fail;
        logic        no_wait;
        logic [7:0]  requester_id;
    } fcpa_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] grow_by;
        logic        wake_valid;
        logic [7:0]  wake_requester;
        logic [15:0] wake_count;
        logic [15:0] units_in_use;
    } fcpa_out_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_READ,
        CTL_EXEC,
        CTL_WAKE,
        CTL_EMIT
    } fcpa_state_t;

    typedef struct packed {
        logic in_take;
        logic exec;
        logic wake;
        logic load;
    } fcpa_cmd_t;

    typedef struct packed {
        logic is_release;
        logic out_free;
    } fcpa_sts_t;

endpackage

`default_nettype wire

>>> hdl/fcpa_ctrl.sv
// Controller state machine sequencing one request through the datapath.
`default_nettype none

module fcpa_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire fcpa_pkg::fcpa_sts_t sts,
    output fcpa_pkg::fcpa_cmd_t    cmd
);
    import fcpa_pkg::*;

    fcpa_state_t state_reg;
    fcpa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE: begin
                if (s_valid) begin
                    state_next = CTL_READ;
                end
            end
            CTL_READ: state_next = CTL_EXEC;
            CTL_EXEC: state_next = sts.is_release ? CTL_WAKE : CTL_EMIT;
            CTL_WAKE: state_next = CTL_EMIT;
            CTL_EMIT: begin
                if (sts.out_free) begin
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            CTL_IDLE: cmd.in_take = 1'b1;
            CTL_READ: cmd = '0;
            CTL_EXEC: cmd.exec = 1'b1;
            CTL_WAKE: cmd.wake = 1'b1;
            CTL_EMIT: cmd.load = sts.out_free;
            default:  cmd = '0;
        endcase
    end

    `include "fair_credit_pool_allocator_unit_assert.svh"

    `FCPA_ASSERT_NEXT(a_accept_reads, aclk, aresetn, s_valid && cmd.in_take, state_reg == CTL_READ)
    `FCPA_ASSERT_IMPL(a_wake_on_release, aclk, aresetn, state_reg == CTL_WAKE, sts.is_release)
    `FCPA_ASSERT_NEXT(a_emit_holds, aclk, aresetn, (state_reg == CTL_EMIT) && !sts.out_free, state_reg == CTL_EMIT)

endmodule

`default_nettype wire

>>> hdl/fcpa_datapath.sv
// Datapath: usage and limit counters, waiter queue memory and result register.
`default_nettype none

module fcpa_datapath #(
    parameter int WAIT_DEPTH = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire logic               s_valid,
    input  wire fcpa_pkg::fcpa_in_t s_data,
    output fcpa_pkg::fcpa_out_t     m_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire fcpa_pkg::fcpa_cmd_t cmd,
    output fcpa_pkg::fcpa_sts_t     sts
);
    import fcpa_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW = $clog2(WAIT_DEPTH + 1);
    localparam int EW = 8 + CB;
    localparam logic [CB-1:0] CountMax   = '1;
    localparam logic [CB-1:0] LimitReset = COUNT_BITS'(32'd16);
    localparam logic [FW-1:0] FillMax    = FW'(WAIT_DEPTH);
    localparam logic [IW:0]   DepthW     = (IW + 1)'(WAIT_DEPTH);
    localparam logic [IW-1:0] LastIdx    = IW'(WAIT_DEPTH - 1);

    fcpa_in_t        req_reg;
    logic [CB-1:0]   cnt_reg;
    logic [CB-1:0]   used_reg,  used_next;
    logic [CB-1:0]   lim_reg,   lim_next;
    logic [IW-1:0]   head_reg,  head_next;
    logic [FW-1:0]   fill_reg,  fill_next;
    logic [2:0]      st_reg,    st_next;
    logic [CB-1:0]   grow_reg,  grow_next;
    logic            wake_v_reg, wake_v_next;
    logic [7:0]      wake_id_reg, wake_id_next;
    logic [CB-1:0]   wake_cnt_reg, wake_cnt_next;
    logic            m_valid_reg;
    fcpa_out_t       m_data_reg;

    logic [EW-1:0]   mem [WAIT_DEPTH];
    logic [EW-1:0]   head_q_reg;
    logic            mem_we;
    logic [IW-1:0]   mem_addr;

    logic [31:0]     cnt32;
    logic [CB-1:0]   cnt_sat;
    logic [CB:0]     sum_ext;
    logic [CB-1:0]   sat_sum;
    logic [CB:0]     grow_diff;
    logic [CB:0]     wsum;
    logic [CB-1:0]   need;
    logic [IW:0]     tail_sum;
    logic [IW:0]     tail_wrap;
    logic [31:0]     grow32;
    logic [31:0]     wcnt32;
    logic [31:0]     used32;
    fcpa_out_t       result;

    // Requests wider than the counter saturate on the way in.
    assign cnt32   = 32'(s_data.request_count);
    assign cnt_sat = (cnt32 > 32'(CountMax)) ? CountMax : cnt32[CB-1:0];

    assign sum_ext   = {1'b0, used_reg} + {1'b0, cnt_reg};
    assign sat_sum   = sum_ext[CB] ? CountMax : sum_ext[CB-1:0];
    assign grow_diff = {1'b0, sat_sum} - {1'b0, lim_reg};
    assign need      = head_q_reg[CB-1:0];
    assign wsum      = {1'b0, need} + {1'b0, used_reg};

    // The queue slot after the last waiter, wrapped by one conditional subtract.
    assign tail_sum  = {1'b0, head_reg} + (IW + 1)'(fill_reg);
    assign tail_wrap = (tail_sum >= DepthW) ? (tail_sum - DepthW) : tail_sum;
    assign mem_addr  = tail_wrap[IW-1:0];

    always_comb begin
        used_next     = used_reg;
        lim_next      = lim_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        st_next       = st_reg;
        grow_next     = grow_reg;
        wake_v_next   = wake_v_reg;
        wake_id_next  = wake_id_reg;
        wake_cnt_next = wake_cnt_reg;
        mem_we        = 1'b0;
        if (cmd.exec) begin
            grow_next     = '0;
            wake_v_next   = 1'b0;
            wake_id_next  = '0;
            wake_cnt_next = '0;
            if (req_reg.action == ACT_RESERVE) begin
                priority if (req_reg.no_fail) begin
                    used_next = sat_sum;
                    st_next   = ST_GRANTED;
                    if (!grow_diff[CB] && (grow_diff[CB-1:0] != '0)) begin
                        grow_next = grow_diff[CB-1:0];
                        lim_next  = sat_sum;
                    end
                end else if (sum_ext <= {1'b0, lim_reg}) begin
                    used_next = sum_ext[CB-1:0];
                    st_next   = ST_GRANTED;
                end else if (req_reg.no_wait) begin
                    st_next = ST_REFUSED;
                end else if (fill_reg == FillMax) begin
                    st_next = ST_QFULL;
                end else begin
                    mem_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    st_next   = ST_QUEUED;
                end
            end else begin
                if (cnt_reg > used_reg) begin
                    used_next = '0;
                    st_next   = ST_UNDERFLOW;
                end else begin
                    used_next = used_reg - cnt_reg;
                    st_next   = ST_RELEASED;
                end
            end
        end else if (cmd.wake) begin
            // Only the head waiter is considered, which keeps service in order.
            if ((fill_reg != '0) && (wsum <= {1'b0, lim_reg})) begin
                used_next     = wsum[CB-1:0];
                wake_v_next   = 1'b1;
                wake_id_next  = head_q_reg[EW-1:CB];
                wake_cnt_next = need;
                head_next     = (head_reg == LastIdx) ? '0 : head_reg + 1'b1;
                fill_next     = fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            lim_reg  <= LimitReset;
            head_reg <= '0;
            fill_reg <= '0;
        end else if (cfg_wr_en) begin
            used_reg <= '0;
            lim_reg  <= CB'(cfg_wr_data);
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            used_reg <= used_next;
            lim_reg  <= lim_next;
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg       <= st_next;
        grow_reg     <= grow_next;
        wake_v_reg   <= wake_v_next;
        wake_id_reg  <= wake_id_next;
        wake_cnt_reg <= wake_cnt_next;
        if (cmd.in_take && s_valid) begin
            req_reg <= s_data;
            cnt_reg <= cnt_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= {req_reg.requester_id, cnt_reg};
        end
        head_q_reg <= mem[head_reg];
    end

    assign grow32 = 32'(grow_reg);
    assign wcnt32 = 32'(wake_cnt_reg);
    assign used32 = 32'(used_reg);

    always_comb begin
        result.status         = st_reg;
        result.grow_by        = grow32[15:0];
        result.wake_valid     = wake_v_reg;
        result.wake_requester = wake_id_reg;
        result.wake_count     = wcnt32[15:0];
        result.units_in_use   = (used32 > 32'h0000_FFFF) ? 16'hFFFF : used32[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign sts.is_release = (req_reg.action == ACT_RELEASE);
    assign sts.out_free   = !m_valid_reg || m_ready;

    `include "fair_credit_pool_allocator_unit_assert.svh"

    `FCPA_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FillMax)
    `FCPA_ASSERT_IMPL(a_used_in_limit, aclk, aresetn, 1'b1, used_reg <= lim_reg)
    `FCPA_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.load, !m_valid_reg || m_ready)

endmodule

`default_nettype wire

>>> hdl/fair_credit_pool_allocator_unit.sv
// Usage notes:
// A credit pool that grants, queues or refuses reserve requests and frees
// units on release, waking the oldest queued waiter when it then fits.
// Requests arrive on the s_ channel (s_valid, s_ready, s_data) and each
// produces exactly one result on the m_ channel (m_valid, m_ready, m_data).
// Each request passes through the controller sequence: latch, queue memory
// read, update, and for a release the head waiter check, then the load of
// the output register. A new request is taken only once the controller has
// loaded the previous result into the output register and returned to idle.
// The output register holds a finished result while the receiver stalls;
// a new request is still taken meanwhile, and it waits before its own
// result load until the earlier result has gone.
// Writing cfg_wr_data with cfg_wr_en sets the limit and empties the pool;
// write only while no request is in flight. Reset (aresetn low,
// synchronous) sets the limit to 16, usage to zero and empties the queue.
`default_nettype none

module fair_credit_pool_allocator_unit #(
    parameter int WAIT_DEPTH = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fcpa_pkg::fcpa_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fcpa_pkg::fcpa_out_t     m_data
);
    import fcpa_pkg::*;

    fcpa_cmd_t cmd;
    fcpa_sts_t sts;

    fcpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    fcpa_datapath #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign s_ready = cmd.in_take;

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the credit pool allocator unit.
`default_nettype none

module tb;
    import fcpa_pkg::*;

    localparam int QUEUE_SLOTS = 16;
    localparam int STALL_CYCLES = 240;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;

    // Tracks usage, limit and the waiter queue, and holds the results owed by the block.
    class credit_pool_tracker;
        logic [15:0] used_now;
        logic [15:0] limit_now;
        logic [7:0]  waiter_id[QUEUE_SLOTS];
        logic [15:0] waiter_need[QUEUE_SLOTS];
        int unsigned head;
        int unsigned fill;
        fcpa_out_t   owed_results[$];
        int          errors;

        function new();
            errors = 0;
            restart(16'd16);
        endfunction

        function void restart(logic [15:0] limit);
            used_now = '0;
            limit_now = limit;
            head = 0;
            fill = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void take_request(fcpa_in_t req);
            fcpa_out_t   res;
            logic [16:0] sum;
            logic [15:0] need;
            int unsigned slot;
            res = '0;
            sum = {1'b0, used_now} + {1'b0, req.request_count};
            if (req.action == ACT_RESERVE) begin
                if (req.no_fail) begin
                    used_now = sum[16] ? 16'hFFFF : sum[15:0];
                    if (used_now > limit_now) begin
                        res.grow_by = used_now - limit_now;
                        limit_now = used_now;
                    end
                    res.status = ST_GRANTED;
                end else if (sum <= {1'b0, limit_now}) begin
                    used_now = sum[15:0];
                    res.status = ST_GRANTED;
                end else if (req.no_wait) begin
                    res.status = ST_REFUSED;
                end else if (fill >= QUEUE_SLOTS) begin
                    res.status = ST_QFULL;
                end else begin
                    slot = (head + fill) % QUEUE_SLOTS;
                    waiter_id[slot] = req.requester_id;
                    waiter_need[slot] = req.request_count;
                    fill++;
                    res.status = ST_QUEUED;
                end
            end else begin
                if (req.request_count > used_now) begin
                    used_now = '0;
                    res.status = ST_UNDERFLOW;
                end else begin
                    used_now = used_now - req.request_count;
                    res.status = ST_RELEASED;
                end
                // Only the head waiter is considered, and at most one per release.
                if (fill > 0) begin
                    need = waiter_need[head];
                    if ({1'b0, need} + {1'b0, used_now} <= {1'b0, limit_now}) begin
                        used_now = used_now + need;
                        res.wake_valid = 1'b1;
                        res.wake_requester = waiter_id[head];
                        res.wake_count = need;
                        head = (head + 1) % QUEUE_SLOTS;
                        fill--;
                    end
                end
            end
            res.units_in_use = used_now;
            owed_results.push_back(res);
        endfunction

        function void field_check(string what, int unsigned want, int unsigned seen);
            if (want !== seen) begin
                $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
                errors++;
            end
        endfunction

        function void check_result(fcpa_out_t got);
            fcpa_out_t want;
            if (owed_results.size() == 0) begin
                $display("%0t: result %h arrived with nothing expected, expected none actual %h",
                         $time, got, got);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            field_check("status", want.status, got.status);
            field_check("grow_by", want.grow_by, got.grow_by);
            field_check("wake_valid", want.wake_valid, got.wake_valid);
            field_check("wake_requester", want.wake_requester, got.wake_requester);
            field_check("wake_count", want.wake_count, got.wake_count);
            field_check("units_in_use", want.units_in_use, got.units_in_use);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    fcpa_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    fcpa_out_t   m_data;

    credit_pool_tracker pool = new();
    bit          hold_request = 1'b0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    fair_credit_pool_allocator_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Transfer monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn && s_valid === 1'b1 && s_ready === 1'b1) begin
            pool.take_request(s_data);
        end
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            pool.check_result(m_data);
        end
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pool.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls on a pattern of its own, and once holds off for a long stretch.
    initial begin : receiver
        int seg_len;
        int mode;
        int k;
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                seg_len = $urandom_range(10, 60);
                mode = $urandom_range(0, 3);
                for (k = 0; k < seg_len; k++) begin
                    case (mode)
                        0: begin
                            m_ready <= 1'b1;
                        end
                        1: begin
                            m_ready <= ($urandom_range(0, 3) != 0);
                        end
                        2: begin
                            m_ready <= ($urandom_range(0, 3) == 0);
                        end
                        default: begin
                            m_ready <= k[2];
                        end
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    function automatic fcpa_in_t make_request(logic action, logic [15:0] count,
                                              logic no_fail, logic no_wait,
                                              logic [7:0] id);
        fcpa_in_t r;
        r.action = action;
        r.request_count = count;
        r.no_fail = no_fail;
        r.no_wait = no_wait;
        r.requester_id = id;
        return r;
    endfunction

    // Mostly well-formed traffic scaled to the current limit, with some noise.
    function automatic fcpa_in_t random_request();
        fcpa_in_t    r;
        int unsigned pick;
        int unsigned span;
        r = make_request(ACT_RESERVE, '0, 1'b0, 1'b0, 8'($urandom));
        pick = $urandom_range(0, 99);
        span = (pool.limit_now == 0) ? 8 : pool.limit_now;
        if (pick < 45) begin
            r.request_count = 16'($urandom_range(1, span / 2 + 1));
            r.no_fail = ($urandom_range(0, 11) == 0);
            r.no_wait = ($urandom_range(0, 2) == 0);
        end else if (pick < 85) begin
            r.action = ACT_RELEASE;
            if ($urandom_range(0, 9) == 0) begin
                r.request_count = 16'($urandom);
            end else begin
                r.request_count = 16'($urandom_range(0, pool.used_now));
            end
            r.no_fail = 1'($urandom);
            r.no_wait = 1'($urandom);
        end else begin
            {r.action, r.request_count, r.no_fail, r.no_wait} = 19'($urandom);
        end
        return r;
    endfunction

    task automatic offer(input fcpa_in_t item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Waits until every owed result has come, then lets the block settle.
    // The first edge lets the monitor note the last input transfer.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pool.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] limit);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pool.restart(limit);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [15:0] phase_limit[6];
        int i;
        int p;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default limit of 16: extremes of the count, flag precedence and underflow.
        offer(make_request(ACT_RESERVE, 16'd0, 1'b0, 1'b0, 8'h00));
        offer(make_request(ACT_RESERVE, 16'd16, 1'b0, 1'b0, 8'h55));
        offer(make_request(ACT_RESERVE, 16'd1, 1'b0, 1'b1, 8'h12));
        offer(make_request(ACT_RESERVE, 16'd1, 1'b1, 1'b1, 8'hFF));
        offer(make_request(ACT_RELEASE, 16'hFFFF, 1'b1, 1'b1, 8'hAA));
        offer(make_request(ACT_RESERVE, 16'hFFFF, 1'b1, 1'b0, 8'h01));
        offer(make_request(ACT_RESERVE, 16'hFFFF, 1'b1, 1'b0, 8'h02));
        offer(make_request(ACT_RELEASE, 16'hFFFF, 1'b0, 1'b0, 8'h00));

        // Limit of zero: an oversized head waiter, a full queue, then growth wakes it.
        write_limit(16'd0);
        offer(make_request(ACT_RESERVE, 16'd5, 1'b0, 1'b0, 8'h01));
        for (i = 1; i < QUEUE_SLOTS; i++) begin
            offer(make_request(ACT_RESERVE, 16'd1, 1'b0, 1'b0, 8'(i * 17)));
        end
        offer(make_request(ACT_RESERVE, 16'd2, 1'b0, 1'b0, 8'hFE));
        offer(make_request(ACT_RELEASE, 16'd0, 1'b0, 1'b0, 8'h00));
        offer(make_request(ACT_RESERVE, 16'd5, 1'b1, 1'b0, 8'h33));
        offer(make_request(ACT_RELEASE, 16'd5, 1'b0, 1'b0, 8'h00));
        offer(make_request(ACT_RELEASE, 16'd5, 1'b0, 1'b0, 8'h00));

        phase_limit[0] = 16'd16;
        phase_limit[1] = 16'd0;
        phase_limit[2] = 16'hFFFF;
        phase_limit[3] = 16'd1;
        phase_limit[4] = 16'($urandom_range(2, 64));
        phase_limit[5] = 16'($urandom);
        for (p = 0; p < 6; p++) begin
            write_limit(phase_limit[p]);
            // The long receiver hold-off lands while the sender keeps offering.
            if (p == 4) begin
                hold_request = 1'b1;
            end
            for (i = 0; i < 75; i++) begin
                offer(random_request());
            end
        end

        drain();
        if (pool.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, pool.pending());
        end
        if (pool.errors == 0 && pool.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
